// ===== hdl/tga_rle_packet_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the TGA RLE packet decoder.
// Each macro expects clk and rst_n to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PACKET_DECODER_MACROS_SVH
`define TGA_RLE_PACKET_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TRPD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TRPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/trpd_pkg.sv =====
// ----------------------------------------------------------------------------
// trpd_pkg
// Shared types and constants of the TGA RLE packet decoder.
// ----------------------------------------------------------------------------
package trpd_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BPP   = 2'd0;
  localparam logic [1:0] CFG_RLE   = 2'd1;
  localparam logic [1:0] CFG_TOTAL = 2'd2;

  // Largest number of pixels carried by one result.
  localparam int LANES = 2;

  // Command passed from the front end to the back end. A count of zero
  // stands for a single result without pixels.
  typedef struct packed {
    logic [31:0] pixel;
    logic [7:0]  cnt;
    logic        img_end;
    logic        ov;
  } cmd_t;

endpackage

// ===== hdl/tga_rle_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_rle_packet_decoder
// Decodes the TGA image-data byte stream into results of up to two pixels.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one byte per transaction (in_valid, in_stall).
//   The front end finishes each byte before it takes the next one. The
//   result channel (out_valid, out_stall) carries pixel pairs. A run packet
//   of N pixels expands into ceil(N/2) results, one per cycle while the
//   output does not stall; the front end keeps parsing bytes meanwhile
//   until the two-entry queue fills, and the back end's run expansion sets
//   the rate for run packets. A byte passes the byte register, the command
//   queue and the back end's command register before its result shows on
//   out_valid; each command is loaded after the last result of the one
//   before. Configuration is written through cfg_wr_en, cfg_index and
//   cfg_wdata; the user is to write it only while the block is idle, which
//   the block does not enforce. Writes to an unused index are ignored. A
//   stalled output holds its result; the queue then fills and the input
//   stalls. Reset (rst_n low at a clock edge) empties the queue and output,
//   restores the register defaults and expects a packet header next.
// ----------------------------------------------------------------------------
module tga_rle_packet_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_first,
  output logic [31:0] out_pixel_second,
  output logic [1:0]  out_pixel_count,
  output logic        out_image_end,
  output logic        out_overrun
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  trpd_pkg::cmd_t push_cmd;
  trpd_pkg::cmd_t head_cmd;

  trpd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  trpd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_cmd  (head_cmd)
  );

  trpd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (head_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_first  (out_pixel_first),
    .out_pixel_second (out_pixel_second),
    .out_pixel_count  (out_pixel_count),
    .out_image_end    (out_image_end),
    .out_overrun      (out_overrun)
  );

endmodule

// ===== hdl/trpd_front.sv =====
// ----------------------------------------------------------------------------
// trpd_front
// Configuration registers, byte capture, packet parsing and pixel assembly.
// Each byte becomes at most one command for the back end.
// ----------------------------------------------------------------------------
module trpd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              q_full,
  output logic              q_push,
  output trpd_pkg::cmd_t    q_cmd
);

  localparam logic F_IDLE = 1'b0;
  localparam logic F_EXEC = 1'b1;

  logic [2:0]  bpp_r;
  logic        rle_r;
  logic [31:0] total_r;

  logic        state_r, state_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        fin_r, fin_nxt;
  logic        in_pix_r, in_pix_nxt;
  logic        run_r, run_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [31:0] asm_r, asm_nxt;
  logic [31:0] done_r, done_nxt;

  logic [32:0] diff;
  logic [2:0]  size;
  logic [31:0] asm_take;
  logic        take_done;
  logic [1:0]  pos_inc;
  logic        rem_small;
  logic [7:0]  hdr_cnt;
  logic        hdr_clip;
  logic        run_clip;
  logic [7:0]  run_cnt;
  logic [7:0]  lit_left;

  assign in_stall = (state_r != F_IDLE);

  // Borrow in bit 32 means the image is already complete.
  assign diff = {1'b0, total_r} - {1'b0, done_r};

  always_comb begin
    case (bpp_r)
      3'd0:                 size = 3'd1;
      3'd1, 3'd2, 3'd3, 3'd4: size = bpp_r;
      default:              size = 3'd4;
    endcase
  end

  always_comb begin
    asm_take = (bip_r == 2'd0) ? 32'h0 : asm_r;
    asm_take[{bip_r, 3'b000} +: 8] = byte_r;
  end

  assign take_done = ({1'b0, bip_r} + 3'd1) >= size;
  assign pos_inc   = bip_r + 2'd1;
  assign rem_small = (rem_r[31:8] == 24'h0);
  assign hdr_cnt   = {1'b0, byte_r[6:0]} + 8'd1;
  assign hdr_clip  = rem_small && (hdr_cnt > rem_r[7:0]);
  assign run_clip  = rem_small && (left_r > rem_r[7:0]);
  assign run_cnt   = run_clip ? rem_r[7:0] : left_r;
  assign lit_left  = (left_r == 8'd0) ? 8'd0 : left_r - 8'd1;

  always_comb begin
    state_nxt  = state_r;
    byte_nxt   = byte_r;
    rem_nxt    = rem_r;
    fin_nxt    = fin_r;
    in_pix_nxt = in_pix_r;
    run_nxt    = run_r;
    left_nxt   = left_r;
    bip_nxt    = bip_r;
    asm_nxt    = asm_r;
    done_nxt   = done_r;
    q_push     = 1'b0;
    q_cmd      = '0;

    if (state_r == F_IDLE) begin
      if (in_valid) begin
        state_nxt = F_EXEC;
        byte_nxt  = in_data_byte;
        rem_nxt   = diff[31:0];
        fin_nxt   = diff[32] || (diff[31:0] == 32'h0);
      end
    end else if (!q_full) begin
      state_nxt = F_IDLE;
      if (fin_r) begin
        q_push   = 1'b1;
        q_cmd.ov = 1'b1;
      end else if (!rle_r) begin
        asm_nxt = asm_take;
        bip_nxt = take_done ? 2'd0 : pos_inc;
        if (take_done) begin
          done_nxt      = done_r + 32'd1;
          q_push        = 1'b1;
          q_cmd.pixel   = asm_take;
          q_cmd.cnt     = 8'd1;
          q_cmd.img_end = (rem_r == 32'd1);
        end
      end else if (!in_pix_r) begin
        // Packet header: the count is clipped to what is left of the image.
        run_nxt    = byte_r[7];
        left_nxt   = hdr_clip ? rem_r[7:0] : hdr_cnt;
        in_pix_nxt = 1'b1;
        bip_nxt    = 2'd0;
        if (hdr_clip) begin
          q_push   = 1'b1;
          q_cmd.ov = 1'b1;
        end
      end else begin
        asm_nxt = asm_take;
        bip_nxt = take_done ? 2'd0 : pos_inc;
        if (take_done) begin
          q_push      = 1'b1;
          q_cmd.pixel = asm_take;
          if (run_r) begin
            done_nxt      = done_r + {24'h0, run_cnt};
            q_cmd.cnt     = run_cnt;
            q_cmd.img_end = ({24'h0, run_cnt} == rem_r);
            q_cmd.ov      = run_clip;
            left_nxt      = 8'd0;
            in_pix_nxt    = 1'b0;
          end else begin
            done_nxt      = done_r + 32'd1;
            q_cmd.cnt     = 8'd1;
            q_cmd.img_end = (rem_r == 32'd1);
            left_nxt      = lit_left;
            if (lit_left == 8'd0) begin
              in_pix_nxt = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= 3'd4;
      rle_r    <= 1'b1;
      total_r  <= 32'h0;
      state_r  <= F_IDLE;
      fin_r    <= 1'b0;
      in_pix_r <= 1'b0;
      run_r    <= 1'b0;
      left_r   <= 8'd0;
      bip_r    <= 2'd0;
      done_r   <= 32'h0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          trpd_pkg::CFG_BPP:   bpp_r   <= cfg_wdata[2:0];
          trpd_pkg::CFG_RLE:   rle_r   <= cfg_wdata[0];
          trpd_pkg::CFG_TOTAL: total_r <= cfg_wdata;
          default: ;
        endcase
      end
      state_r  <= state_nxt;
      fin_r    <= fin_nxt;
      in_pix_r <= in_pix_nxt;
      run_r    <= run_nxt;
      left_r   <= left_nxt;
      bip_r    <= bip_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    rem_r  <= rem_nxt;
    asm_r  <= asm_nxt;
  end

endmodule

// ===== hdl/trpd_fifo.sv =====
// ----------------------------------------------------------------------------
// trpd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module trpd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  trpd_pkg::cmd_t    push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output trpd_pkg::cmd_t    head_cmd
);

  trpd_pkg::cmd_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_cmd  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/trpd_back.sv =====
// ----------------------------------------------------------------------------
// trpd_back
// Expands commands into results of up to two pixels and holds the output
// register of the result channel.
// ----------------------------------------------------------------------------
`include "tga_rle_packet_decoder_macros.svh"

module trpd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  trpd_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_pixel_first,
  output logic [31:0]       out_pixel_second,
  output logic [1:0]        out_pixel_count,
  output logic              out_image_end,
  output logic              out_overrun
);

  localparam logic [7:0] LANES8 = 8'(trpd_pkg::LANES);

  logic           act_r, act_nxt;
  trpd_pkg::cmd_t cur_r, cur_nxt;
  logic [7:0]     left_r, left_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [31:0]    out_first_r, out_first_nxt;
  logic [31:0]    out_second_r, out_second_nxt;
  logic [1:0]     out_count_r, out_count_nxt;
  logic           out_end_r, out_end_nxt;
  logic           out_ov_r, out_ov_nxt;

  logic           slot_free;
  logic           last;
  logic [7:0]     k;

  assign slot_free = !out_valid_r || !out_stall;
  assign last      = (left_r <= LANES8);
  assign k         = last ? left_r : LANES8;
  assign q_pop     = !act_r && q_valid;

  always_comb begin
    act_nxt        = act_r;
    cur_nxt        = cur_r;
    left_nxt       = left_r;
    out_valid_nxt  = out_valid_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_count_nxt  = out_count_r;
    out_end_nxt    = out_end_r;
    out_ov_nxt     = out_ov_r;

    if (!act_r) begin
      if (q_valid) begin
        act_nxt  = 1'b1;
        cur_nxt  = q_cmd;
        left_nxt = q_cmd.cnt;
      end
      if (slot_free) begin
        out_valid_nxt = 1'b0;
      end
    end else if (slot_free) begin
      // Flags of a command belong to its final result only.
      out_valid_nxt  = 1'b1;
      out_first_nxt  = (left_r == 8'd0) ? 32'h0 : cur_r.pixel;
      out_second_nxt = (k > 8'd1) ? cur_r.pixel : 32'h0;
      out_count_nxt  = k[1:0];
      out_end_nxt    = cur_r.img_end && last;
      out_ov_nxt     = cur_r.ov && last;
      left_nxt       = left_r - k;
      if (last) begin
        act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      left_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_count_r  <= out_count_nxt;
    out_end_r    <= out_end_nxt;
    out_ov_r     <= out_ov_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_first  = out_first_r;
  assign out_pixel_second = out_second_r;
  assign out_pixel_count  = out_count_r;
  assign out_image_end    = out_end_r;
  assign out_overrun      = out_ov_r;

  `TRPD_ASSERT(a_second_zero, out_valid_r && (out_count_r != 2'd2), out_second_r == 32'h0, "second pixel set in a result with fewer than two pixels")
  `TRPD_ASSERT(a_end_has_pixel, out_valid_r && out_end_r, out_count_r != 2'd0, "image end marked on a result without pixels")
  `TRPD_ASSERT_NEXT(a_run_continues, act_r && slot_free && (left_r > LANES8), act_r && (left_r == $past(left_r) - LANES8), "run expansion lost pixels")

endmodule

// ===== sim/tga_rle_packet_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// tga_rle_packet_decoder_tb
// Self-checking testbench for the TGA RLE packet decoder. A directed
// sequence covers the packet corner cases, and random phases follow with
// new register settings. Every accepted byte runs through a local decoder
// model; each result transaction is compared field by field against it.
// ----------------------------------------------------------------------------
module tga_rle_packet_decoder_tb;

  localparam int CLK_PERIOD        = 8;
  localparam int MAX_CYCLES        = 1_200_000;
  localparam int SETTLE_CYCLES     = 16;
  localparam int PIXELS_PER_RESULT = 2;
  localparam int RANDOM_PHASES     = 10;
  localparam int PHASE_BYTES       = 29;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
    logic [1:0]  count;
    logic        img_end;
    logic        ov;
  } pixel_pair_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_wdata = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_pixel_first;
  logic [31:0] out_pixel_second;
  logic [1:0]  out_pixel_count;
  logic        out_image_end;
  logic        out_overrun;

  tga_rle_packet_decoder dut (.*);

  // Decoder model: register copies and packet state.
  logic [2:0]  bpp_cfg = 3'd4;
  logic        rle_cfg = 1'b1;
  logic [31:0] total_cfg = 32'd0;
  logic        in_packet = 1'b0;
  logic        run_packet = 1'b0;
  logic [7:0]  pkt_left = 8'd0;
  logic [1:0]  byte_pos = 2'd0;
  logic [31:0] pixel_acc = 32'd0;
  logic [31:0] done_count = 32'd0;

  pixel_pair_t expected_pairs[$];
  logic [7:0]  pending_bytes[$];

  int unsigned sent_count = 0;
  int unsigned taken_count = 0;
  int unsigned results_seen = 0;
  int unsigned results_paced = 0;
  int unsigned in_hold = 0;
  int unsigned out_hold = 0;
  int unsigned in_gap_max = 11;
  int unsigned out_gap_max = 11;
  int unsigned bytes_queued = 0;
  int          error_count = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * MAX_CYCLES);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [2:0] pixel_size();
    if (bpp_cfg == 3'd0) return 3'd1;
    if (bpp_cfg > 3'd4) return 3'd4;
    return bpp_cfg;
  endfunction

  // Adds one byte to the pixel under assembly; returns 1 once it is complete.
  function automatic bit add_pixel_byte(input logic [7:0] b);
    logic [1:0] pos;
    pos = byte_pos;
    if (pos == 2'd0) pixel_acc = 32'd0;
    pixel_acc = pixel_acc | ({24'd0, b} << (8 * pos));
    if ({1'b0, pos} + 3'd1 >= pixel_size()) begin
      byte_pos = 2'd0;
      return 1'b1;
    end
    byte_pos = pos + 2'd1;
    return 1'b0;
  endfunction

  function automatic void queue_pair(input logic [31:0] first, input logic [31:0] second,
                                     input logic [1:0] count, input logic img_end,
                                     input logic ov);
    pixel_pair_t p;
    p.first = first;
    p.second = second;
    p.count = count;
    p.img_end = img_end;
    p.ov = ov;
    expected_pairs.push_back(p);
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic [31:0] left;
    logic [31:0] n_pix;
    logic [1:0]  lane_n;
    logic        clipped;
    if (done_count >= total_cfg) begin
      queue_pair(32'd0, 32'd0, 2'd0, 1'b0, 1'b1);
      return;
    end
    left = total_cfg - done_count;
    if (!rle_cfg) begin
      if (add_pixel_byte(b)) begin
        done_count = done_count + 1;
        queue_pair(pixel_acc, 32'd0, 2'd1, done_count == total_cfg, 1'b0);
      end
      return;
    end
    if (!in_packet) begin
      // Packet header: the count is clipped to the pixels that remain.
      run_packet = b[7];
      n_pix = {25'd0, b[6:0]} + 32'd1;
      clipped = n_pix > left;
      if (clipped) n_pix = left;
      pkt_left = n_pix[7:0];
      in_packet = 1'b1;
      byte_pos = 2'd0;
      if (clipped) queue_pair(32'd0, 32'd0, 2'd0, 1'b0, 1'b1);
      return;
    end
    if (!add_pixel_byte(b)) return;
    if (run_packet) begin
      // The total may have been lowered since the header, so clip again.
      n_pix = {24'd0, pkt_left};
      clipped = n_pix > left;
      if (clipped) n_pix = left;
      while (n_pix > 0) begin
        lane_n = (n_pix >= PIXELS_PER_RESULT) ? 2'(PIXELS_PER_RESULT) : n_pix[1:0];
        done_count = done_count + lane_n;
        n_pix = n_pix - lane_n;
        queue_pair(pixel_acc, (lane_n > 2'd1) ? pixel_acc : 32'd0, lane_n,
                   done_count == total_cfg, clipped && n_pix == 0);
      end
      pkt_left = 8'd0;
      in_packet = 1'b0;
      return;
    end
    done_count = done_count + 1;
    queue_pair(pixel_acc, 32'd0, 2'd1, done_count == total_cfg, 1'b0);
    if (pkt_left > 0) pkt_left = pkt_left - 8'd1;
    if (pkt_left == 0) in_packet = 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(negedge clk) begin : driver
    if (rst_n) begin
      // A presented byte stays put until its transaction completes.
      if (!(in_valid && taken_count != sent_count)) begin
        if (in_hold > 0) begin
          in_valid <= 1'b0;
          in_hold--;
        end else if (pending_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_data_byte <= pending_bytes.pop_front();
          sent_count++;
          in_hold = $urandom_range(0, in_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (results_seen != results_paced) begin
        results_paced = results_seen;
        out_hold = $urandom_range(0, out_gap_max);
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    pixel_pair_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_pairs.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %h %h %0d %b %b", $time,
                   out_pixel_first, out_pixel_second, out_pixel_count, out_image_end,
                   out_overrun);
        end else begin
          want = expected_pairs.pop_front();
          check_field("pixel_first", want.first, out_pixel_first);
          check_field("pixel_second", want.second, out_pixel_second);
          check_field("pixel_count", {30'd0, want.count}, {30'd0, out_pixel_count});
          check_field("image_end", {31'd0, want.img_end}, {31'd0, out_image_end});
          check_field("overrun", {31'd0, want.ov}, {31'd0, out_overrun});
        end
      end
      if (in_valid && !in_stall) begin
        decode_byte(in_data_byte);
        taken_count++;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      trpd_pkg::CFG_BPP:   bpp_cfg = value[2:0];
      trpd_pkg::CFG_RLE:   rle_cfg = value[0];
      trpd_pkg::CFG_TOTAL: total_cfg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Waits until every byte is taken and every result has arrived, then lets
  // a header or partial pixel still in flight settle.
  task automatic drain();
    while (!(pending_bytes.size() == 0 && taken_count == sent_count &&
             expected_pairs.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_packet();
    int unsigned n_pix;
    int unsigned n_bytes;
    logic [7:0]  hdr;
    if (!rle_cfg || $urandom_range(0, 9) == 0) begin
      // Raw pixel data, or stray bytes that break the packet alignment.
      repeat ($urandom_range(1, 8)) queue_byte(8'($urandom_range(0, 255)));
      return;
    end
    hdr[7] = $urandom_range(0, 1);
    if (hdr[7]) n_pix = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 128)
                                                    : $urandom_range(1, 6);
    else        n_pix = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20)
                                                    : $urandom_range(1, 4);
    hdr[6:0] = 7'(n_pix - 1);
    queue_byte(hdr);
    n_bytes = hdr[7] ? pixel_size() : n_pix * pixel_size();
    repeat (n_bytes) queue_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    logic [31:0] junk;
    logic [31:0] new_total;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: an image of zero pixels, so the byte overruns.
    queue_byte(8'h00);
    drain();

    // Longest run packet, then a literal packet and a one-pixel run.
    write_reg(trpd_pkg::CFG_BPP, 32'd1);
    write_reg(trpd_pkg::CFG_TOTAL, 32'hFFFF_FFFF);
    queue_byte(8'hFF); queue_byte(8'hA5);
    queue_byte(8'h01); queue_byte(8'h00); queue_byte(8'hFF);
    queue_byte(8'h80); queue_byte(8'h5A);
    drain();

    // Size zero acts as one byte; the run is clipped at the header and the
    // trailing byte lands past the end of the image.
    write_reg(trpd_pkg::CFG_BPP, 32'd0);
    write_reg(trpd_pkg::CFG_TOTAL, done_count + 32'd5);
    queue_byte(8'h85); queue_byte(8'h3C); queue_byte(8'h11);
    drain();

    // Size seven acts as four; stop in the middle of a pixel.
    write_reg(trpd_pkg::CFG_BPP, 32'd7);
    write_reg(trpd_pkg::CFG_TOTAL, done_count + 32'd10);
    queue_byte(8'h83); queue_byte(8'h12); queue_byte(8'h34);
    drain();

    // Shrinking the size to two completes the pixel with the next byte.
    write_reg(trpd_pkg::CFG_BPP, 32'd2);
    queue_byte(8'h56); queue_byte(8'h89);
    drain();

    // Lowering the total between header and pixel clips the run again.
    write_reg(trpd_pkg::CFG_TOTAL, done_count + 32'd10);
    queue_byte(8'h85);
    drain();
    write_reg(trpd_pkg::CFG_TOTAL, done_count + 32'd3);
    queue_byte(8'hAB); queue_byte(8'hCD);
    drain();

    // Raw mode with three-byte pixels, then one byte past the end.
    write_reg(trpd_pkg::CFG_RLE, 32'd0);
    write_reg(trpd_pkg::CFG_BPP, 32'd3);
    write_reg(trpd_pkg::CFG_TOTAL, done_count + 32'd2);
    queue_byte(8'h01); queue_byte(8'h02); queue_byte(8'h03);
    queue_byte(8'hFE); queue_byte(8'hFD); queue_byte(8'hFC); queue_byte(8'h77);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 3)
        0: begin in_gap_max = 11; out_gap_max = 11; end
        1: begin in_gap_max = 0; out_gap_max = 0; end
        default: begin
          in_gap_max = $urandom_range(0, 1) ? 11 : 0;
          out_gap_max = $urandom_range(0, 1) ? 11 : 0;
        end
      endcase
      junk = $urandom;
      write_reg(trpd_pkg::CFG_BPP, {junk[31:3], 3'($urandom_range(0, 7))});
      junk = $urandom;
      write_reg(trpd_pkg::CFG_RLE, {junk[31:1], ($urandom_range(0, 4) != 0)});
      case ($urandom_range(0, 9))
        0:       new_total = 32'd0;
        1:       new_total = 32'hFFFF_FFFF;
        2:       new_total = done_count + $urandom_range(1, 8);
        default: new_total = done_count + $urandom_range(20, 300);
      endcase
      write_reg(trpd_pkg::CFG_TOTAL, new_total);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom);
      bytes_queued = 0;
      while (bytes_queued < PHASE_BYTES) begin
        queue_packet();
        // Now and then hold the input back until the output has drained.
        if ($urandom_range(0, 19) == 0) drain();
        while (pending_bytes.size() > 8) @(posedge clk);
      end
      drain();
    end

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/trpd_pkg.sv
hdl/trpd_front.sv
hdl/trpd_fifo.sv
hdl/trpd_back.sv
hdl/tga_rle_packet_decoder.sv
sim/tga_rle_packet_decoder_tb.sv
